[design/assert_macros.svh]
// Assertion helpers shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define DBLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks an implication whose consequent starts in the cycle after the antecedent.
`define DBLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dbls_pkg.sv]
package dbls_pkg;

  // Width of every configuration register.
  localparam int unsigned CfgW = 16;
  // Default width of the tick counters.
  localparam int unsigned CountWidthDefault = 16;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 3;

  // Register values after reset.
  localparam logic [CfgW-1:0] DebounceReset = 16'd10;
  localparam logic [CfgW-1:0] BucketReset   = 16'd500;
  localparam logic [CfgW-1:0] MinPlayReset  = 16'd100;
  localparam logic [CfgW-1:0] LightReset    = 16'd20;
  localparam logic [CfgW-1:0] BellReset     = 16'd5;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    IDX_DEBOUNCE = 3'd0,
    IDX_BUCKET   = 3'd1,
    IDX_MIN_PLAY = 3'd2,
    IDX_LIGHT    = 3'd3,
    IDX_BELL     = 3'd4
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIGHT_GO,
    ST_LIGHT_WAIT,
    ST_BELL_GO,
    ST_BELL_WAIT,
    ST_STEP,
    ST_OUT
  } seq_state_e;

  // Status returned by the remainder unit.
  typedef struct packed {
    logic done;
    logic hit;
  } rem_status_t;

endpackage

[design/dbls_rem_unit.sv]
`include "assert_macros.svh"

module dbls_rem_unit #(
  parameter int unsigned CountWidth = dbls_pkg::CountWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [CountWidth-1:0]     dividend_i,
  input  logic [dbls_pkg::CfgW-1:0] divisor_i,
  output dbls_pkg::rem_status_t     status_o
);

  localparam int unsigned StepW = $clog2(CountWidth);
  localparam int unsigned RemW  = dbls_pkg::CfgW;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [CountWidth-1:0] quo_q, quo_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic [RemW-1:0]       div_q, div_d;
  logic [RemW:0]         trial;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial  = {rem_q, quo_q[CountWidth-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[CountWidth-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = RemW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[RemW-1:0];
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(CountWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // A zero divisor never counts as a hit.
  assign status_o.done = done_q;
  assign status_o.hit  = (rem_q == '0) && (div_q != '0);

  `DBLS_ASSERT(a_start_when_free, !(start_i && busy_q), "start issued while the unit is busy")
  `DBLS_ASSERT_NEXT(a_done_one_cycle, done_q, !done_q, "done held longer than one cycle")
  `DBLS_ASSERT_NEXT(a_busy_ends_done, busy_q && !busy_d, done_q, "iteration ended without done")

endmodule

[design/debounced_bell_light_sequencer_unit.sv]
// Debounced bell and light sequencer, one timer tick per input word.
// Input channel: in_valid_i / in_ready_o carry one word per tick, holding the
// raw button level on button_pressed_i. Output channel: out_valid_o /
// out_ready_i deliver one result word per input word: light level, bell pulse,
// debounced level, stability flag and playback flag.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 debounce ticks, 1 bucket limit, 2 minimum play ticks, 3 light period,
// 4 bell period); other indexes are ignored. Write only while idle.
// A tick that leaves the countdown at zero goes from acceptance straight to
// the output state. A tick that runs a countdown step first passes through
// the light and bell remainder checks and then the step state: one shared
// restoring remainder unit checks the countdown against the light period and
// then the bell period, one bit per cycle. One word is in flight at a time;
// in_ready_o is high only while the sequencer is idle, so a new word is taken
// only once the previous result has been loaded into the output register.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; a stalled receiver holds the sequencer in its output
// state once the next result is ready.
// Reset clears all tick state, loads the default register values and empties
// the output register.
`include "assert_macros.svh"

module debounced_bell_light_sequencer_unit #(
  parameter int unsigned CountWidth = dbls_pkg::CountWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dbls_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dbls_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         button_pressed_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         light_level_o,
  output logic                         bell_fire_o,
  output logic                         debounced_level_o,
  output logic                         level_stable_o,
  output logic                         playing_o
);

  localparam int unsigned CfgW = dbls_pkg::CfgW;
  localparam int unsigned CmpW = (CountWidth > CfgW) ? CountWidth : CfgW;

  // Configuration registers.
  logic [CfgW-1:0] debounce_q, bucket_lim_q, min_play_q, light_per_q, bell_per_q;

  // Tick state.
  logic                  last_q, last_d;
  logic [CountWidth-1:0] same_q, same_d;
  logic                  stable_q, stable_d;
  logic                  pend_q, pend_d;
  logic [CountWidth-1:0] bucket_q, bucket_d;
  logic [CountWidth-1:0] remain_q, remain_d;
  logic [CountWidth-1:0] elapsed_q, elapsed_d;
  logic                  stop_q, stop_d;
  logic                  light_q, light_d;
  logic                  light_hit_q, light_hit_d;
  logic                  bell_q, bell_d;

  // Sequencer and output register.
  dbls_pkg::seq_state_e  state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic                  in_fire;

  // Remainder unit interface.
  logic                  rem_start;
  logic [CfgW-1:0]       rem_divisor;
  dbls_pkg::rem_status_t rem_sts;

  // Sequencer conditions watched by the checks below.
  logic                  rem_wait;
  logic                  out_free;

  assign in_ready_o = (state_q == dbls_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= dbls_pkg::DebounceReset;
      bucket_lim_q <= dbls_pkg::BucketReset;
      min_play_q   <= dbls_pkg::MinPlayReset;
      light_per_q  <= dbls_pkg::LightReset;
      bell_per_q   <= dbls_pkg::BellReset;
    end else if (cfg_we_i) begin
      unique case (dbls_pkg::cfg_idx_e'(cfg_idx_i))
        dbls_pkg::IDX_DEBOUNCE: debounce_q   <= cfg_data_i;
        dbls_pkg::IDX_BUCKET:   bucket_lim_q <= cfg_data_i;
        dbls_pkg::IDX_MIN_PLAY: min_play_q   <= cfg_data_i;
        dbls_pkg::IDX_LIGHT:    light_per_q  <= cfg_data_i;
        dbls_pkg::IDX_BELL:     bell_per_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared remainder unit: countdown modulo the light or bell period.
  dbls_rem_unit #(
    .CountWidth (CountWidth)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (remain_q),
    .divisor_i  (rem_divisor),
    .status_o   (rem_sts)
  );

  assign rem_divisor = (state_q == dbls_pkg::ST_LIGHT_GO) ? light_per_q : bell_per_q;

  // Next state, tick update and countdown step.
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    same_d      = same_q;
    stable_d    = stable_q;
    pend_d      = pend_q;
    bucket_d    = bucket_q;
    remain_d    = remain_q;
    elapsed_d   = elapsed_q;
    stop_d      = stop_q;
    light_d     = light_q;
    light_hit_d = light_hit_q;
    bell_d      = bell_q;
    rem_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      dbls_pkg::ST_IDLE: begin
        if (in_fire) begin
          bell_d = 1'b0;
          // Debounce: restart the count on a level change.
          if (button_pressed_i != last_q) begin
            last_d   = button_pressed_i;
            same_d   = '0;
            stable_d = 1'b0;
          end
          if ((CmpW'(same_d) < CmpW'(debounce_q)) && (same_d != '1)) begin
            same_d = same_d + 1'b1;
          end else if (!stable_d) begin
            stable_d = 1'b1;
            pend_d   = 1'b1;
          end
          // A new stable edge starts playback or requests a stop; the bucket leaks.
          if (stable_d) begin
            if (pend_d) begin
              if (last_d) begin
                remain_d  = bucket_q;
                elapsed_d = '0;
              end else begin
                stop_d = 1'b1;
              end
              pend_d = 1'b0;
            end
            if (last_d) begin
              if (bucket_q != '0) begin
                bucket_d = bucket_q - 1'b1;
              end
            end else if ((CmpW'(bucket_q) < CmpW'(bucket_lim_q)) && (bucket_q != '1)) begin
              bucket_d = bucket_q + 1'b1;
            end
          end
          // The stop leaves one final countdown step once the minimum has passed.
          if (stop_d && (CmpW'(elapsed_d) >= CmpW'(min_play_q))) begin
            remain_d = CountWidth'(1);
            stop_d   = 1'b0;
          end
          state_d = (remain_d != '0) ? dbls_pkg::ST_LIGHT_GO : dbls_pkg::ST_OUT;
        end
      end
      dbls_pkg::ST_LIGHT_GO: begin
        rem_start = 1'b1;
        state_d   = dbls_pkg::ST_LIGHT_WAIT;
      end
      dbls_pkg::ST_LIGHT_WAIT: begin
        if (rem_sts.done) begin
          light_hit_d = rem_sts.hit;
          state_d     = dbls_pkg::ST_BELL_GO;
        end
      end
      dbls_pkg::ST_BELL_GO: begin
        rem_start = 1'b1;
        state_d   = dbls_pkg::ST_BELL_WAIT;
      end
      dbls_pkg::ST_BELL_WAIT: begin
        if (rem_sts.done) begin
          bell_d  = rem_sts.hit;
          state_d = dbls_pkg::ST_STEP;
        end
      end
      dbls_pkg::ST_STEP: begin
        // One countdown step; the light goes off when the countdown ends.
        remain_d = remain_q - 1'b1;
        light_d  = light_q ^ light_hit_q;
        if (remain_d == '0) begin
          light_d = 1'b0;
        end
        if (elapsed_q != '1) begin
          elapsed_d = elapsed_q + 1'b1;
        end
        state_d = dbls_pkg::ST_OUT;
      end
      dbls_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = dbls_pkg::ST_IDLE;
        end
      end
      default: state_d = dbls_pkg::ST_IDLE;
    endcase
  end

  // Sequencer and tick state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbls_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      same_q      <= '0;
      stable_q    <= 1'b0;
      pend_q      <= 1'b0;
      bucket_q    <= '0;
      remain_q    <= '0;
      elapsed_q   <= '0;
      stop_q      <= 1'b0;
      light_q     <= 1'b0;
      light_hit_q <= 1'b0;
      bell_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      same_q      <= same_d;
      stable_q    <= stable_d;
      pend_q      <= pend_d;
      bucket_q    <= bucket_d;
      remain_q    <= remain_d;
      elapsed_q   <= elapsed_d;
      stop_q      <= stop_d;
      light_q     <= light_d;
      light_hit_q <= light_hit_d;
      bell_q      <= bell_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      light_level_o     <= light_q;
      bell_fire_o       <= bell_q;
      debounced_level_o <= last_q;
      level_stable_o    <= stable_q;
      playing_o         <= (remain_q != '0);
    end
  end

  assign out_valid_o = out_valid_q;

  // The remainder unit is only waited on in the two wait states.
  assign rem_wait = (state_q == dbls_pkg::ST_LIGHT_WAIT) || (state_q == dbls_pkg::ST_BELL_WAIT);
  assign out_free = (state_q == dbls_pkg::ST_OUT) && !out_valid_q;

  `DBLS_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "accepted a word while busy")
  `DBLS_ASSERT(a_done_in_wait, !rem_sts.done || rem_wait, "remainder done outside a wait state")
  `DBLS_ASSERT_NEXT(a_out_free_loads, out_free, in_ready_o && out_valid_q, "result not loaded")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CfgW    = dbls_pkg::CfgW;
  localparam int unsigned CfgIdxW = dbls_pkg::CfgIdxW;

  // One result word as the block reports it after a tick.
  typedef struct packed {
    logic light;
    logic bell;
    logic level;
    logic stable;
    logic playing;
  } tick_result_t;

  localparam logic [CfgW-1:0] CountMax = {CfgW{1'b1}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = dbls_pkg::IDX_DEBOUNCE;
  logic [CfgW-1:0]     cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                button = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tick_result_t        observed;

  debounced_bell_light_sequencer_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .button_pressed_i  (button),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .light_level_o     (observed.light),
    .bell_fire_o       (observed.bell),
    .debounced_level_o (observed.level),
    .level_stable_o    (observed.stable),
    .playing_o         (observed.playing)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies used for prediction, starting at their reset values.
  logic [CfgW-1:0] debounce_cfg = dbls_pkg::DebounceReset;
  logic [CfgW-1:0] bucket_limit_cfg = dbls_pkg::BucketReset;
  logic [CfgW-1:0] min_play_cfg = dbls_pkg::MinPlayReset;
  logic [CfgW-1:0] light_cfg = dbls_pkg::LightReset;
  logic [CfgW-1:0] bell_cfg = dbls_pkg::BellReset;

  // Tick state of the sequencer as predicted.
  logic            raw_prev = 1'b0;
  logic [CfgW-1:0] stable_run = '0;
  logic            settled = 1'b0;
  logic            edge_pending = 1'b0;
  logic [CfgW-1:0] bucket = '0;
  logic [CfgW-1:0] countdown = '0;
  logic [CfgW-1:0] elapsed = '0;
  logic            stop_pending = 1'b0;
  logic            lamp = 1'b0;

  logic         tick_queue[$];
  tick_result_t pending_results[$];
  int           mismatch_count = 0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           ready_left = 0;
  int           stall_left = 0;

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgW-1:0] value);
    case (idx)
      dbls_pkg::IDX_DEBOUNCE: debounce_cfg = value;
      dbls_pkg::IDX_BUCKET:   bucket_limit_cfg = value;
      dbls_pkg::IDX_MIN_PLAY: min_play_cfg = value;
      dbls_pkg::IDX_LIGHT:    light_cfg = value;
      dbls_pkg::IDX_BELL:     bell_cfg = value;
      default: ;
    endcase
  endfunction

  // Advances the predicted sequencer by one tick and returns its result word.
  function automatic tick_result_t advance_tick(input logic pressed);
    tick_result_t r;
    r = '0;
    // Debounce the raw level.
    if (pressed != raw_prev) begin
      raw_prev = pressed;
      stable_run = '0;
      settled = 1'b0;
    end
    if (stable_run < debounce_cfg && stable_run != CountMax) begin
      stable_run = stable_run + 1'b1;
    end else if (!settled) begin
      settled = 1'b1;
      edge_pending = 1'b1;
    end
    // A new stable level starts playback or asks for a stop; the bucket leaks.
    if (settled) begin
      if (edge_pending) begin
        if (raw_prev) begin
          countdown = bucket;
          elapsed = '0;
        end else begin
          stop_pending = 1'b1;
        end
        edge_pending = 1'b0;
      end
      if (raw_prev) begin
        if (bucket != '0) bucket = bucket - 1'b1;
      end else if (bucket < bucket_limit_cfg && bucket != CountMax) begin
        bucket = bucket + 1'b1;
      end
    end
    // A stop applies only after the minimum playback time.
    if (stop_pending && elapsed >= min_play_cfg) begin
      countdown = CfgW'(1);
      stop_pending = 1'b0;
    end
    // One countdown step.
    if (countdown != '0) begin
      if (light_cfg != '0 && countdown % light_cfg == '0) lamp = !lamp;
      if (bell_cfg != '0 && countdown % bell_cfg == '0) r.bell = 1'b1;
      countdown = countdown - 1'b1;
      if (elapsed != CountMax) elapsed = elapsed + 1'b1;
      if (countdown == '0) lamp = 1'b0;
    end
    r.light = lamp;
    r.level = raw_prev;
    r.stable = settled;
    r.playing = (countdown != '0);
    return r;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    apply_reg(idx, value);
  endtask

  task automatic configure(input logic [CfgW-1:0] debounce, input logic [CfgW-1:0] limit,
                           input logic [CfgW-1:0] min_play, input logic [CfgW-1:0] light,
                           input logic [CfgW-1:0] bell);
    write_reg(dbls_pkg::IDX_DEBOUNCE, debounce);
    write_reg(dbls_pkg::IDX_BUCKET, limit);
    write_reg(dbls_pkg::IDX_MIN_PLAY, min_play);
    write_reg(dbls_pkg::IDX_LIGHT, light);
    write_reg(dbls_pkg::IDX_BELL, bell);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Blocks until every queued tick is accepted and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly clean press and release runs longer than the debounce time,
  // mixed with short bounces and single noisy samples.
  task automatic push_random_ticks(input int count);
    int   hold;
    int   kind;
    logic pressed;
    pressed = $urandom_range(0, 1);
    while (count > 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        pressed = !pressed;
        if (debounce_cfg > 40) hold = $urandom_range(1, 40);
        else hold = debounce_cfg + 1 + $urandom_range(0, ($urandom_range(0, 3) == 0) ? 80 : 20);
      end else if (kind < 9) begin
        pressed = !pressed;
        hold = $urandom_range(1, (debounce_cfg > 40) ? 40 :
                                 ((debounce_cfg == '0) ? 1 : int'(debounce_cfg)));
      end else begin
        pressed = $urandom_range(0, 1);
        hold = 1;
      end
      repeat (hold) begin
        if (count > 0) begin
          tick_queue.push_back(pressed);
          count--;
        end
      end
    end
  endtask

  task automatic push_pattern(input string bits);
    foreach (bits[i]) tick_queue.push_back(bits[i] == "1");
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      button <= 1'b0;
    end else begin
      if (in_valid && in_ready) pending_results.push_back(advance_tick(button));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          in_valid <= 1'b1;
          button <= tick_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) == 0) gap_left = 0;
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(7, 45);
            else gap_left = $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_bit(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: ready stretches broken by stalls, and checks each result word.
  always @(posedge clk or negedge rst_n) begin
    tick_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %b", $time, observed);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          compare_bit("light_level", want.light, observed.light);
          compare_bit("bell_fire", want.bell, observed.bell);
          compare_bit("debounced_level", want.level, observed.level);
          compare_bit("level_stable", want.stable, observed.stable);
          compare_bit("playing", want.playing, observed.playing);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (ready_left > 0) begin
        ready_left--;
        out_ready <= 1'b1;
      end else begin
        ready_left = $urandom_range(1, 30);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        out_ready <= (stall_left == 0);
      end
    end
  end

  // Stimulus: directed settings first, then random phases over many settings.
  initial begin
    int phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Immediate debounce, stop while idle, every tick hitting the light period.
    configure(16'd0, 16'd4, 16'd0, 16'd1, 16'd2);
    write_reg(dbls_pkg::IDX_BELL + 1'b1, CountMax);
    write_reg({CfgIdxW{1'b1}}, '0);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_pattern("000000111010101");
    wait_drained();

    // Bounce shorter than the debounce time, zero bell period, minimum play.
    configure(16'd2, 16'd3, 16'd2, 16'd3, 16'd0);
    push_pattern("01011111000011");
    wait_drained();

    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: configure(16'd3, 16'd20, 16'd5, 16'd4, 16'd3);
        1: configure(16'd1, CountMax, 16'd0, CountMax, 16'd1);
        2: configure(16'd0, 16'd0, CountMax, 16'd1, CountMax);
        3: configure(CountMax, 16'd30, 16'd10, 16'd2, 16'd2);
        4: configure(dbls_pkg::DebounceReset, dbls_pkg::BucketReset, dbls_pkg::MinPlayReset,
                     dbls_pkg::LightReset, dbls_pkg::BellReset);
        5: configure(16'd2, 16'd12, 16'd3, 16'd0, 16'd0);
        default: configure(CfgW'($urandom_range(0, 6)),
                           CfgW'(($urandom_range(0, 4) == 0) ? $urandom
                                                             : $urandom_range(0, 60)),
                           CfgW'(($urandom_range(0, 5) == 0) ? $urandom
                                                             : $urandom_range(0, 40)),
                           CfgW'($urandom_range(0, 9)), CfgW'($urandom_range(0, 9)));
      endcase
      // The widest debounce never settles, so that phase stays short.
      push_random_ticks((phase == 3) ? 40 : 160);
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS debounced_bell_light_sequencer_unit");
    end else begin
      $display("FAIL debounced_bell_light_sequencer_unit");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL debounced_bell_light_sequencer_unit");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/dbls_pkg.sv
design/dbls_rem_unit.sv
design/debounced_bell_light_sequencer_unit.sv
verif/testbench.sv
